### rtl/core/prime_count_sieve_top_assert.svh
// Assertion macros for the prime count sieve.
`ifndef PRIME_COUNT_SIEVE_TOP_ASSERT_SVH
`define PRIME_COUNT_SIEVE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/pcs_pkg.sv
// Package: constants, sequencer states and map request type of the prime count sieve.
`timescale 1ns / 1ps
package pcs_pkg;

	localparam int MAX_LIMIT = 65535;
	localparam int LIMIT_W   = 16;
	localparam int MAP_AW    = 16;
	localparam int ADDR_W    = MAP_AW + 1;
	localparam int PRIME_W   = 9;
	localparam int SQ_W      = 17;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_PREAD,
		S_PEVAL,
		S_MARK,
		S_COUNT,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic              wdata;
		logic [MAP_AW-1:0] addr;
	} map_req_t;

endpackage

### rtl/core/pcs_map.sv
// Composite bitmap: single-port bit memory with registered read data.
`timescale 1ns / 1ps
module pcs_map (
	input  logic              clk,
	input  pcs_pkg::map_req_t req,
	output logic              rdata
);
	import pcs_pkg::*;

	logic mem_q [2**MAP_AW];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem_q[req.addr] <= req.wdata;
			end
			rdata_q <= mem_q[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/prime_count_sieve_top.sv
// Top level: sequencer and shared address adder of the prime count sieve.
// A limit below two or above the bound is answered in the cycle after accept. Otherwise the
//   bit map is cleared, each candidate whose square is within the limit is tested, each small
//   prime has its multiples marked from its square, the map is counted from 2 to limit, then drained.
// Throughput: one item at a time; the next item is taken in the cycle that shows done.
// Results are shown for one cycle on done and cannot be stalled. Reset clears the sequencer and done.
`timescale 1ns / 1ps
module prime_count_sieve_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] limit,
	output logic        busy,
	output logic        done,
	output logic [15:0] prime_count,
	output logic        out_of_range
);
	import pcs_pkg::*;

	`include "prime_count_sieve_top_assert.svh"

	state_t              state_q, state_d;
	logic [LIMIT_W-1:0]  limit_q;
	logic [ADDR_W-1:0]   addr_q, addr_sum;
	logic [PRIME_W-1:0]  p_q;
	logic [SQ_W-1:0]     sq_q, sq_next;
	logic [LIMIT_W-1:0]  count_q;
	logic                rd_vld_s1;
	logic                done_q;
	logic [LIMIT_W-1:0]  prime_count_q;
	logic                oor_q;

	map_req_t            map_req;
	logic                map_rdata;

	logic                accept, in_oor, early, in_range, sq_in, sq_next_in;
	logic                advance_p, load_mark, to_count, rd_issue, result_load;
	logic [LIMIT_W-1:0]  res_count;
	logic                res_oor;

	pcs_map u_map (
		.clk   (clk),
		.req   (map_req),
		.rdata (map_rdata)
	);

	assign accept     = start && (state_q == S_IDLE);
	assign in_oor     = 32'(limit) > 32'(MAX_LIMIT);
	assign early      = in_oor || (limit < LIMIT_W'(2));
	assign in_range   = addr_q <= {1'b0, limit_q};
	assign addr_sum   = addr_q + ((state_q == S_MARK) ? ADDR_W'(p_q) : ADDR_W'(1));
	assign sq_next    = sq_q + SQ_W'({p_q, 1'b1});
	assign sq_in      = sq_q <= SQ_W'(limit_q);
	assign sq_next_in = sq_next <= SQ_W'(limit_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !early) state_d = S_CLEAR;
			end
			S_CLEAR: begin
				if (!in_range) state_d = sq_in ? S_PREAD : S_COUNT;
			end
			S_PREAD: begin
				state_d = S_PEVAL;
			end
			S_PEVAL: begin
				if (map_rdata) state_d = sq_next_in ? S_PREAD : S_COUNT;
				else state_d = S_MARK;
			end
			S_MARK: begin
				if (!in_range) state_d = sq_next_in ? S_PREAD : S_COUNT;
			end
			S_COUNT: begin
				if (!in_range) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		map_req     = '0;
		advance_p   = 1'b0;
		load_mark   = 1'b0;
		rd_issue    = 1'b0;
		result_load = 1'b0;
		res_count   = '0;
		res_oor     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				result_load = accept && early;
				res_oor     = in_oor;
			end
			S_CLEAR: begin
				map_req.en    = in_range;
				map_req.we    = in_range;
				map_req.wdata = 1'b0;
				map_req.addr  = addr_q[MAP_AW-1:0];
			end
			S_PREAD: begin
				map_req.en   = 1'b1;
				map_req.addr = MAP_AW'(p_q);
			end
			S_PEVAL: begin
				advance_p = map_rdata;
				load_mark = !map_rdata;
			end
			S_MARK: begin
				map_req.en    = in_range;
				map_req.we    = in_range;
				map_req.wdata = 1'b1;
				map_req.addr  = addr_q[MAP_AW-1:0];
				advance_p     = !in_range;
			end
			S_COUNT: begin
				map_req.en   = in_range;
				map_req.addr = addr_q[MAP_AW-1:0];
				rd_issue     = in_range;
			end
			S_DRAIN: begin
				result_load = 1'b1;
				res_count   = count_q;
			end
			default: begin
				map_req = '0;
			end
		endcase
	end

	assign to_count = (state_d == S_COUNT) && (state_q != S_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			done_q    <= result_load;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			limit_q <= limit;
			addr_q  <= '0;
			p_q     <= PRIME_W'(2);
			sq_q    <= SQ_W'(4);
			count_q <= '0;
		end else begin
			// advance the shared address on clear, mark and count steps
			if (((state_q == S_CLEAR) || (state_q == S_MARK) || (state_q == S_COUNT))
				&& in_range) begin
				addr_q <= addr_sum;
			end
			if (load_mark) begin
				addr_q <= ADDR_W'(sq_q);
			end
			if (advance_p) begin
				p_q  <= p_q + PRIME_W'(1);
				sq_q <= sq_next;
			end
			if (to_count) begin
				addr_q <= ADDR_W'(2);
			end
			if (rd_vld_s1 && !map_rdata) begin
				count_q <= count_q + LIMIT_W'(1);
			end
		end
		if (result_load) begin
			prime_count_q <= res_count;
			oor_q         <= res_oor;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign prime_count  = prime_count_q;
	assign out_of_range = oor_q;

	`PCS_ASSERT_IMP(a_oor_zero, clk, arst_n, done && out_of_range, prime_count == '0,
		"out of range result with nonzero count")
	`PCS_ASSERT_NXT(a_accept_resp, clk, arst_n, start && !busy, busy || done,
		"accepted item neither started nor answered")
	`PCS_ASSERT_IMP(a_mark_bound, clk, arst_n, (state_q == S_MARK) && map_req.we,
		{1'b0, map_req.addr} <= {1'b0, limit_q}, "mark beyond limit")
	`PCS_ASSERT_IMP(a_idle_no_map, clk, arst_n, !busy, !map_req.we,
		"bit map written while idle")

endmodule
